// ===== rtl/abs_wheel_brake_controller_assert.svh =====
// Assertion macros shared by the wheel brake controller RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ABS_WHEEL_BRAKE_CONTROLLER_ASSERT_SVH
`define ABS_WHEEL_BRAKE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition implies the consequence in the same cycle.
`define ABSWBC_ASSERT_SAME(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("same-cycle check failed");

// The condition implies the consequence in the next cycle.
`define ABSWBC_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("next-cycle check failed");

`else

`define ABSWBC_ASSERT_SAME(label, cond, conseq)
`define ABSWBC_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

// ===== rtl/abswbc_pkg.sv =====
// Types and constants for the wheel brake controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package abswbc_pkg;

  localparam int SPEED_W = 16;

  typedef logic signed [1:0] drive_t;

  // Actuator commands.
  localparam drive_t DRIVE_ACCEL   = 2'sb01;
  localparam drive_t DRIVE_HOLD    = 2'sb00;
  localparam drive_t DRIVE_SLOW    = 2'sb11;
  localparam drive_t DRIVE_RELEASE = 2'sb10;

  // Status from the accumulator to the decision logic.
  typedef struct packed {
    logic               block_done;
    logic [SPEED_W-1:0] average;
  } acc_res_t;

endpackage

// ===== rtl/abswbc_accum.sv =====
// Block accumulator: sums speed samples and forms the block average by shift.
// Depends on abswbc_pkg.
`timescale 1ns / 1ps

module abswbc_accum #(
  parameter int BLOCK_LENGTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [abswbc_pkg::SPEED_W-1:0] sample,
  output abswbc_pkg::acc_res_t       res
);
  import abswbc_pkg::*;

  localparam int SHIFT = $clog2(BLOCK_LENGTH);
  localparam int CNT_W = (SHIFT < 1) ? 1 : SHIFT;
  localparam int SUM_W = SPEED_W + SHIFT;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_LENGTH - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] total;
  logic             last;

  // The item at the input register closes a block when the count is at its end.
  assign last  = (count_r == LAST_IDX);
  assign total = sum_r + SUM_W'(sample);

  assign res.block_done = last;
  assign res.average    = total[SUM_W-1:SHIFT];

  // Next count and sum; both restart after the last item of a block.
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (advance) begin
      if (last) begin
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        sum_nxt   = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== rtl/abswbc_decide.sv =====
// Drive decision at the end of a block, with the previous block average.
// Depends on abswbc_pkg.
`timescale 1ns / 1ps

module abswbc_decide (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           commit,
  input  abswbc_pkg::acc_res_t           acc,
  input  logic [abswbc_pkg::SPEED_W-1:0] target_speed,
  input  logic                           other_locked,
  output abswbc_pkg::drive_t             drive,
  output logic                           own_locked
);
  import abswbc_pkg::*;

  logic [SPEED_W-1:0] prev_avg_r, prev_avg_nxt;
  logic               avg_zero;

  assign avg_zero = (acc.average == '0);

  // Braking uses the lock rule; otherwise a bang-bang law against the target.
  always_comb begin
    own_locked = 1'b0;
    drive      = DRIVE_HOLD;
    if (target_speed == '0) begin
      own_locked = (acc.average == prev_avg_r) && !avg_zero;
      if (own_locked || other_locked || avg_zero) begin
        drive = DRIVE_HOLD;
      end else begin
        drive = DRIVE_RELEASE;
      end
    end else if (target_speed > acc.average) begin
      drive = DRIVE_ACCEL;
    end else if (target_speed < acc.average) begin
      drive = DRIVE_SLOW;
    end
  end

  // The average is remembered whenever a block completes.
  assign prev_avg_nxt = commit ? acc.average : prev_avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_avg_r <= '0;
    end else begin
      prev_avg_r <= prev_avg_nxt;
    end
  end

endmodule

// ===== rtl/abs_wheel_brake_controller.sv =====
// Wheel brake controller for one wheel: block averaging and drive decision.
// The block takes one item in every cycle unless in_stall is raised. Each
// accepted item is registered, then added into the block sum in the following
// cycle; the item that closes a block of BLOCK_LENGTH items (a power of two)
// also yields a result, which the result register takes and shows on the
// result ports once it is free. The sustained rate is one item per clock
// while no result waits on out_stall, set by the single accumulator add and
// the compare of the decision. A result that waits on out_stall holds back
// only the item that would close the next block; other items keep flowing.
// Depends on abswbc_pkg, abswbc_accum, abswbc_decide and the assertion header.
`timescale 1ns / 1ps

module abs_wheel_brake_controller #(
  parameter int BLOCK_LENGTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [abswbc_pkg::SPEED_W-1:0] in_speed_sample,
  input  logic [abswbc_pkg::SPEED_W-1:0] in_target_speed,
  input  logic                           in_other_wheel_locked,
  output logic                           out_valid,
  input  logic                           out_stall,
  output abswbc_pkg::drive_t             out_drive,
  output logic                           out_own_wheel_locked,
  output logic [abswbc_pkg::SPEED_W-1:0] out_average_speed
);
  import abswbc_pkg::*;

  `include "abs_wheel_brake_controller_assert.svh"

  // Input register.
  logic               s1_valid_r, s1_valid_nxt;
  logic [SPEED_W-1:0] s1_sample_r;
  logic [SPEED_W-1:0] s1_target_r;
  logic               s1_other_r;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  drive_t             out_drive_r;
  logic               out_own_r;
  logic [SPEED_W-1:0] out_avg_r;

  acc_res_t acc;
  drive_t   dec_drive;
  logic     dec_own;
  logic     out_free;
  logic     advance;
  logic     commit;
  logic     in_take;

  // An item moves on unless it closes a block and the result register holds a stalled result.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!acc.block_done || out_free);
  assign commit   = advance && acc.block_done;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  abswbc_accum #(
    .BLOCK_LENGTH(BLOCK_LENGTH)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .sample  (s1_sample_r),
    .res     (acc)
  );

  abswbc_decide u_decide (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (commit),
    .acc          (acc),
    .target_speed (s1_target_r),
    .other_locked (s1_other_r),
    .drive        (dec_drive),
    .own_locked   (dec_own)
  );

  // Valid bits of both registers.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_speed_sample;
      s1_target_r <= in_target_speed;
      s1_other_r  <= in_other_wheel_locked;
    end
    if (commit) begin
      out_drive_r <= dec_drive;
      out_own_r   <= dec_own;
      out_avg_r   <= acc.average;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = out_drive_r;
  assign out_own_wheel_locked = out_own_r;
  assign out_average_speed    = out_avg_r;

  // A stall toward the source only comes from an item held at the input register.
  `ABSWBC_ASSERT_SAME(a_stall_has_item, in_stall, s1_valid_r)
  // A completed block always shows a result in the next cycle.
  `ABSWBC_ASSERT_NEXT(a_commit_shows, commit, out_valid_r)
  // A locked wheel always holds the brake.
  `ABSWBC_ASSERT_SAME(a_lock_holds, out_valid_r && out_own_r, out_drive_r == DRIVE_HOLD)
  // A result is never overwritten while it is stalled.
  `ABSWBC_ASSERT_SAME(a_no_overwrite, out_valid_r && out_stall, !commit)

endmodule
